@@ hdl/first_fit_partition_allocator_unit_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the partition allocator
// Concurrent checks on the rising clock edge, disabled while in reset.
// ----------------------------------------------------------------------------
`ifndef FIRST_FIT_PARTITION_ALLOCATOR_UNIT_MACROS_SVH
`define FIRST_FIT_PARTITION_ALLOCATOR_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS
// Check that a property holds at every edge.
`define FFPA_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Check that the consequent holds whenever the antecedent holds.
`define FFPA_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
// Check that the consequent holds in the cycle after the antecedent.
`define FFPA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define FFPA_ASSERT(lbl, clk, rst_n, prop, msg)
`define FFPA_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg)
`define FFPA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

@@ hdl/ffpa_pkg.sv @@
// ----------------------------------------------------------------------------
// Partition allocator package
// Sizes, operation and status codes, payload and control types.
// ----------------------------------------------------------------------------
package ffpa_pkg;

	localparam int PARTITIONS = 16;
	localparam int IDX_W      = (PARTITIONS > 1) ? $clog2(PARTITIONS) : 1;
	localparam int CNT_W      = $clog2(PARTITIONS + 1);
	localparam int ADDR_W     = 32;
	localparam int SIZE_W     = 32;
	localparam int SLOT_W     = 4;

	localparam logic [1:0] KIND_ADD   = 2'd0;
	localparam logic [1:0] KIND_ALLOC = 2'd1;
	localparam logic [1:0] KIND_FREE  = 2'd2;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_MISS = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;

	typedef struct packed {
		logic [1:0]        kind;
		logic [ADDR_W-1:0] address;
		logic [SIZE_W-1:0] size;
	} ffpa_req_t;

	typedef struct packed {
		logic [1:0]        status;
		logic [ADDR_W-1:0] granted_address;
		logic [SLOT_W-1:0] slot;
	} ffpa_rsp_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SEARCH,
		S_UPDATE
	} ffpa_state_t;

	typedef struct packed {
		logic load;
		logic search;
		logic update;
	} ffpa_cmd_t;

endpackage

@@ hdl/first_fit_partition_allocator_unit.sv @@
// Each accepted transfer passes through the search state (parallel compare and first-hit
// pick) and then the update state (table write), in which the result strobe is given.
// A new transfer is taken in the update state while the table write completes; busy is high only during search.
// The result strobe lasts one cycle; the receiver cannot stall it.
// Reset (arst_n low, asynchronous) empties the table and returns the controller to idle.
// ----------------------------------------------------------------------------
// First-fit partition allocator
// Fixed partition table with add, allocate and free-by-address operations.
// ----------------------------------------------------------------------------
module first_fit_partition_allocator_unit
	import ffpa_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	output logic      busy,
	input  ffpa_req_t req,
	output logic      done,
	output ffpa_rsp_t rsp
);

	ffpa_cmd_t cmd;

	ffpa_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd)
	);

	ffpa_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.req    (req),
		.rsp    (rsp)
	);

endmodule

@@ hdl/ffpa_ctrl.sv @@
// ----------------------------------------------------------------------------
// Partition allocator controller
// Sequences each operation through a search state and an update state.
// ----------------------------------------------------------------------------
`include "first_fit_partition_allocator_unit_macros.svh"

module ffpa_ctrl
	import ffpa_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	output logic      busy,
	output logic      done,
	output ffpa_cmd_t cmd
);

	ffpa_state_t state_q;
	ffpa_state_t state_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next = state_q;
		case (state_q)
			S_IDLE: begin
				if (start) state_next = S_SEARCH;
			end
			S_SEARCH: begin
				state_next = S_UPDATE;
			end
			S_UPDATE: begin
				// take the next transfer while the table write completes
				state_next = start ? S_SEARCH : S_IDLE;
			end
			default: begin
				state_next = S_IDLE;
			end
		endcase
	end

	always_comb begin
		busy       = 1'b0;
		cmd.search = 1'b0;
		cmd.update = 1'b0;
		case (state_q)
			S_IDLE: begin
			end
			S_SEARCH: begin
				busy       = 1'b1;
				cmd.search = 1'b1;
			end
			S_UPDATE: begin
				cmd.update = 1'b1;
			end
			default: begin
			end
		endcase
		cmd.load = start && !busy;
		done     = cmd.update;
	end

	`FFPA_ASSERT_NEXT(a_load_then_search, clk, arst_n, cmd.load, cmd.search && busy, "accepted transfer did not enter search")
	`FFPA_ASSERT_NEXT(a_search_then_done, clk, arst_n, cmd.search, done && !busy, "search not followed by result strobe")
	`FFPA_ASSERT_IMPLY(a_done_after_search, clk, arst_n, done, $past(cmd.search), "result strobe without a preceding search")

endmodule

@@ hdl/ffpa_dp.sv @@
// ----------------------------------------------------------------------------
// Partition allocator datapath
// Partition table, parallel compare with first-hit pick, result register.
// ----------------------------------------------------------------------------
`include "first_fit_partition_allocator_unit_macros.svh"

module ffpa_dp
	import ffpa_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  ffpa_cmd_t cmd,
	input  ffpa_req_t req,
	output ffpa_rsp_t rsp
);

	ffpa_req_t               req_q;
	logic [ADDR_W-1:0]       base_q   [PARTITIONS];
	logic [SIZE_W-1:0]       length_q [PARTITIONS];
	logic [PARTITIONS-1:0]   free_q;
	logic [CNT_W-1:0]        count_q;

	logic [PARTITIONS-1:0]   fit_vec;
	logic [PARTITIONS-1:0]   match_vec;
	logic [PARTITIONS-1:0]   sel_vec;
	logic                    hit;
	logic [IDX_W-1:0]        pick;
	logic                    full;
	logic [IDX_W-1:0]        tail_idx;
	ffpa_rsp_t               rsp_next;

	ffpa_rsp_t               rsp_s1;
	logic                    wr_add_s1;
	logic                    wr_set_s1;
	logic                    wr_clr_s1;
	logic [IDX_W-1:0]        wr_idx_s1;

	always_ff @(posedge clk) begin
		if (cmd.load) req_q <= req;
	end

	// Compare every occupied entry at once
	always_comb begin
		for (int i = 0; i < PARTITIONS; i++) begin
			fit_vec[i]   = (CNT_W'(i) < count_q) && free_q[i] &&
			               (length_q[i] >= req_q.size);
			match_vec[i] = (CNT_W'(i) < count_q) && (base_q[i] == req_q.address);
		end
		sel_vec = (req_q.kind == KIND_ALLOC) ? fit_vec : match_vec;
	end

	// Lowest index wins
	always_comb begin
		hit  = 1'b0;
		pick = '0;
		for (int i = PARTITIONS - 1; i >= 0; i--) begin
			if (sel_vec[i]) begin
				hit  = 1'b1;
				pick = IDX_W'(i);
			end
		end
	end

	assign full     = (count_q == CNT_W'(PARTITIONS));
	assign tail_idx = count_q[IDX_W-1:0];

	always_comb begin
		rsp_next.status          = ST_MISS;
		rsp_next.granted_address = '0;
		rsp_next.slot            = '0;
		case (req_q.kind)
			KIND_ADD: begin
				if (full) begin
					rsp_next.status = ST_FULL;
				end else begin
					rsp_next.status          = ST_OK;
					rsp_next.granted_address = req_q.address;
					rsp_next.slot            = SLOT_W'(tail_idx);
				end
			end
			KIND_ALLOC, KIND_FREE: begin
				if (hit) begin
					rsp_next.status          = ST_OK;
					rsp_next.granted_address = base_q[pick];
					rsp_next.slot            = SLOT_W'(pick);
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.search) begin
			rsp_s1    <= rsp_next;
			wr_add_s1 <= (req_q.kind == KIND_ADD) && !full;
			wr_clr_s1 <= (req_q.kind == KIND_ALLOC) && hit;
			wr_set_s1 <= (req_q.kind == KIND_FREE) && hit;
			wr_idx_s1 <= pick;
		end
	end

	// Table write; req_q still holds the searched operation here
	always_ff @(posedge clk) begin
		if (cmd.update) begin
			if (wr_add_s1) begin
				base_q[tail_idx]   <= req_q.address;
				length_q[tail_idx] <= req_q.size;
				free_q[tail_idx]   <= 1'b1;
			end
			if (wr_set_s1) free_q[wr_idx_s1] <= 1'b1;
			if (wr_clr_s1) free_q[wr_idx_s1] <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.update && wr_add_s1) begin
			count_q <= count_q + CNT_W'(1);
		end
	end

	assign rsp = rsp_s1;

	`FFPA_ASSERT(a_count_bound, clk, arst_n, count_q <= CNT_W'(PARTITIONS), "entry count beyond table size")
	`FFPA_ASSERT_IMPLY(a_count_moves_on_add, clk, arst_n, count_q != $past(count_q), $past(cmd.update && wr_add_s1), "entry count changed outside an add update")
	`FFPA_ASSERT_IMPLY(a_miss_zero_fields, clk, arst_n, cmd.update && rsp_s1.status != ST_OK, rsp_s1.granted_address == '0 && rsp_s1.slot == '0, "failed result carries nonzero fields")

endmodule

@@ bench/first_fit_partition_allocator_unit_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Partition allocator testbench
// Drives add, allocate, free and unused-kind commands with random gaps, keeps
// its own copy of the partition table to predict each response, and compares
// every response strobe against the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;
	import ffpa_pkg::*;

	localparam logic [1:0] KIND_UNUSED = 2'd3;
	localparam int CLK_HALF   = 6;
	localparam int RAND_ITEMS = 1950;
	localparam int IDLE_LIMIT = 5000;
	localparam int MAX_REPORT = 10;

	// Table shadow and pending responses.
	class alloc_tracker;
		logic [ADDR_W-1:0] base_tbl [PARTITIONS];
		logic [SIZE_W-1:0] len_tbl [PARTITIONS];
		bit                free_tbl [PARTITIONS];
		int                n_entries;
		ffpa_rsp_t         pending_rsp [$];
		int                n_errors;

		function new();
			n_entries = 0;
			n_errors  = 0;
		endfunction

		function void note_request(ffpa_req_t item);
			ffpa_rsp_t r;
			bit hit;
			r.status          = ST_MISS;
			r.granted_address = '0;
			r.slot            = '0;
			hit = 1'b0;
			case (item.kind)
				KIND_ADD: begin
					if (n_entries >= PARTITIONS) begin
						r.status = ST_FULL;
					end else begin
						base_tbl[n_entries] = item.address;
						len_tbl[n_entries]  = item.size;
						free_tbl[n_entries] = 1'b1;
						r.status          = ST_OK;
						r.granted_address = item.address;
						r.slot            = SLOT_W'(n_entries);
						n_entries++;
					end
				end
				KIND_ALLOC: begin
					// first free entry large enough wins
					for (int i = 0; i < n_entries && !hit; i++) begin
						if (free_tbl[i] && len_tbl[i] >= item.size) begin
							hit = 1'b1;
							free_tbl[i]       = 1'b0;
							r.status          = ST_OK;
							r.granted_address = base_tbl[i];
							r.slot            = SLOT_W'(i);
						end
					end
				end
				KIND_FREE: begin
					for (int i = 0; i < n_entries && !hit; i++) begin
						if (base_tbl[i] == item.address) begin
							hit = 1'b1;
							free_tbl[i]       = 1'b1;
							r.status          = ST_OK;
							r.granted_address = base_tbl[i];
							r.slot            = SLOT_W'(i);
						end
					end
				end
				default: ;
			endcase
			pending_rsp = {pending_rsp, r};
		endfunction

		function void check_response(ffpa_rsp_t got);
			ffpa_rsp_t exp;
			if (pending_rsp.size() == 0) begin
				n_errors++;
				if (n_errors <= MAX_REPORT)
					$display("%0t: unexpected response status=%0d addr=%h slot=%0d",
						$realtime, got.status, got.granted_address, got.slot);
			end else begin
				exp = pending_rsp.pop_front();
				if (got.status !== exp.status || got.granted_address !== exp.granted_address ||
						got.slot !== exp.slot) begin
					n_errors++;
					if (n_errors <= MAX_REPORT)
						$display("%0t: mismatch exp %0d/%h/%0d got %0d/%h/%0d",
							$realtime, exp.status, exp.granted_address, exp.slot,
							got.status, got.granted_address, got.slot);
				end
			end
		endfunction
	endclass

	logic      clk    = 1'b0;
	logic      arst_n = 1'b0;
	logic      start  = 1'b0;
	logic      busy;
	ffpa_req_t req    = '0;
	logic      done;
	ffpa_rsp_t rsp;

	alloc_tracker sb = new();

	logic [ADDR_W-1:0] known_bases [$];
	logic [SIZE_W-1:0] known_lens [$];
	int                idle_cycles = 0;

	first_fit_partition_allocator_unit i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.req    (req),
		.done   (done),
		.rsp    (rsp)
	);

	initial begin
		forever #CLK_HALF clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (done)
				sb.check_response(rsp);
			if (start && !busy)
				sb.note_request(req);
		end
	end

	// Count cycles with no transfer and no response.
	always @(posedge clk) begin
		if (arst_n && !(start && !busy) && !done)
			idle_cycles++;
		else
			idle_cycles = 0;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("%0t: watchdog expired", $realtime);
			$display("CHECKS FAILED");
			$finish;
		end
	end

	function automatic ffpa_req_t mk_req(logic [1:0] kind, logic [ADDR_W-1:0] addr,
			logic [SIZE_W-1:0] size);
		ffpa_req_t item;
		item.kind    = kind;
		item.address = addr;
		item.size    = size;
		return item;
	endfunction

	function automatic int pick_gap(int idx);
		int r;
		if ((idx % 250) < 40)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		else if (r < 85)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	function automatic ffpa_req_t random_request();
		ffpa_req_t item;
		int r;
		int sel;
		item.address = $urandom;
		item.size    = $urandom;
		r = $urandom_range(0, 99);
		if (r < 15) begin
			item.kind = KIND_ADD;
			sel = $urandom_range(0, 99);
			if (known_bases.size() > 0 && sel < 20)
				item.address = known_bases[$urandom_range(0, known_bases.size() - 1)];
			sel = $urandom_range(0, 99);
			if (sel < 35)
				item.size = $urandom_range(0, 4096);
			else if (sel < 45)
				item.size = '0;
			else if (sel < 55)
				item.size = '1;
		end else if (r < 57) begin
			item.kind = KIND_ALLOC;
			sel = $urandom_range(0, 99);
			if (sel < 10)
				item.size = '0;
			else if (sel < 15)
				item.size = '1;
			else if (sel < 75 && known_lens.size() > 0)
				item.size = known_lens[$urandom_range(0, known_lens.size() - 1)] +
					SIZE_W'($urandom_range(0, 2)) - SIZE_W'(1);
			else if (sel < 88)
				item.size = $urandom_range(0, 8192);
		end else if (r < 95) begin
			item.kind = KIND_FREE;
			if (known_bases.size() > 0 && $urandom_range(0, 99) < 80)
				item.address = known_bases[$urandom_range(0, known_bases.size() - 1)];
		end else begin
			item.kind = KIND_UNUSED;
		end
		return item;
	endfunction

	task automatic send_item(ffpa_req_t item, int gap);
		if (item.kind == KIND_ADD && known_bases.size() < PARTITIONS) begin
			known_bases = {known_bases, item.address};
			known_lens  = {known_lens, item.size};
		end
		start <= 1'b1;
		req   <= item;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		// hold start high when the next transfer follows directly
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic wait_drained();
		start <= 1'b0;
		while (sb.pending_rsp.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// empty table: every lookup misses
		send_item(mk_req(KIND_ALLOC, 32'h0, 32'h0), pick_gap(1));
		send_item(mk_req(KIND_FREE, 32'h0, 32'h0), pick_gap(1));
		send_item(mk_req(KIND_UNUSED, 32'h0, 32'h0), pick_gap(1));
		send_item(mk_req(KIND_ADD, 32'h0, 32'h0), pick_gap(1));
		send_item(mk_req(KIND_ADD, 32'hffff_ffff, 32'hffff_ffff), pick_gap(1));
		send_item(mk_req(KIND_ADD, 32'h0000_1000, 32'h0000_0100), pick_gap(1));
		send_item(mk_req(KIND_ADD, 32'h0000_1000, 32'h0000_0200), pick_gap(1));
		send_item(mk_req(KIND_ALLOC, 32'hffff_ffff, 32'h0), pick_gap(1));
		send_item(mk_req(KIND_ALLOC, 32'h0, 32'hffff_ffff), pick_gap(1));
		send_item(mk_req(KIND_ALLOC, 32'h0, 32'hffff_ffff), pick_gap(1));
		send_item(mk_req(KIND_ALLOC, 32'h0, 32'h0000_0100), pick_gap(1));
		send_item(mk_req(KIND_ALLOC, 32'h0, 32'h0000_0100), pick_gap(1));
		send_item(mk_req(KIND_ALLOC, 32'h0, 32'h0), pick_gap(1));
		// duplicate base: only the first match is released
		send_item(mk_req(KIND_FREE, 32'h0000_1000, 32'hffff_ffff), pick_gap(1));
		send_item(mk_req(KIND_FREE, 32'h0000_1000, 32'h0), pick_gap(1));
		send_item(mk_req(KIND_FREE, 32'h1234_5678, 32'h0), pick_gap(1));
		send_item(mk_req(KIND_FREE, 32'h0, 32'h0), pick_gap(1));
		send_item(mk_req(KIND_FREE, 32'hffff_ffff, 32'h0), pick_gap(1));
		send_item(mk_req(KIND_ALLOC, 32'h0, 32'h0000_0101), pick_gap(1));
		send_item(mk_req(KIND_ALLOC, 32'h0, 32'h0000_0201), pick_gap(1));
		send_item(mk_req(KIND_UNUSED, 32'hffff_ffff, 32'hffff_ffff), pick_gap(1));
		wait_drained();

		for (int i = 0; i < RAND_ITEMS; i++) begin
			send_item(random_request(), pick_gap(i));
			if (i == RAND_ITEMS / 2)
				wait_drained();
		end
		wait_drained();
		repeat (8) @(posedge clk);

		if (sb.n_errors == 0 && sb.pending_rsp.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
